### rtl/scrs_pkg.sv
// Package for the SHA-256 counter-mode byte stream: types, round constants,
// command/status structs shared by controller and datapath. No dependencies.
`default_nettype none
package scrs_pkg;

	localparam int unsigned DIGEST_BYTES = 32;
	localparam logic [7:0]  BYTE_MASK    = 8'hFF;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_WORD    = 2'd1,
		KIND_UNIFORM = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_SEED_W0 = 2'd0,
		CFG_SEED_W1 = 2'd1,
		CFG_SEED_W2 = 2'd2,
		CFG_SEED_W3 = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_HASH_INIT,
		ST_HASH_ROUND,
		ST_HASH_FINAL,
		ST_TAKE_BYTE,
		ST_LIMIT_INIT,
		ST_LIMIT_STEP,
		ST_CHECK,
		ST_MOD_INIT,
		ST_MOD_STEP,
		ST_RESULT,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;     // capture kind/bound
		logic restart;      // clear counter, empty buffer
		logic hash_init;    // load message schedule and working vars
		logic hash_round;   // one compression round
		logic hash_final;   // add chaining value, fill buffer
		logic take_byte;    // shift next byte into accumulator
		logic clr_acc;      // clear accumulator and byte count
		logic lim_init;     // start 2^32 / n division
		logic div_step;     // one restoring-division step
		logic mod_init;     // start word / n division
		logic set_zero;     // result is zero
		logic set_acc;      // result is accumulator
		logic set_rem;      // result is remainder
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		kind_t kind;
		logic  small_bound;   // n <= 1
		logic  buf_empty;     // read position at 32
		logic  buf_last;      // read position at 31: last byte left
		logic  round_last;    // round 63 in progress
		logic  acc_full;      // fourth byte is the next one taken
		logic  div_last;      // last division step
		logic  reject;        // word at or above limit
	} dp_sts_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

### rtl/scrs_ctrl.sv
// Controller state machine for the SHA-256 counter-mode byte stream.
// Depends on scrs_pkg; drives the datapath with dp_cmd_t, reads dp_sts_t.
`default_nettype none
module scrs_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire              out_ready,
	output scrs_pkg::dp_cmd_t cmd,
	input  scrs_pkg::dp_sts_t sts
);
	import scrs_pkg::*;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (in_valid) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				unique case (sts.kind)
					KIND_RESTART: state_d = ST_RESULT;
					KIND_UNIFORM: state_d = sts.small_bound ? ST_RESULT : ST_LIMIT_INIT;
					default:      state_d = sts.buf_empty ? ST_HASH_INIT : ST_TAKE_BYTE;
				endcase
			end
			ST_HASH_INIT:  state_d = ST_HASH_ROUND;
			ST_HASH_ROUND: if (sts.round_last) state_d = ST_HASH_FINAL;
			ST_HASH_FINAL: state_d = ST_TAKE_BYTE;
			ST_TAKE_BYTE: begin
				if (sts.kind == KIND_BYTE || sts.acc_full) begin
					state_d = (sts.kind == KIND_UNIFORM) ? ST_CHECK : ST_RESULT;
				end else begin
					state_d = sts.buf_last ? ST_HASH_INIT : ST_TAKE_BYTE;
				end
			end
			ST_LIMIT_INIT: state_d = ST_LIMIT_STEP;
			ST_LIMIT_STEP: if (sts.div_last) state_d = sts.buf_empty ? ST_HASH_INIT : ST_TAKE_BYTE;
			ST_CHECK:      state_d = sts.reject ?
			                         (sts.buf_empty ? ST_HASH_INIT : ST_TAKE_BYTE) : ST_MOD_INIT;
			ST_MOD_INIT:   state_d = ST_MOD_STEP;
			ST_MOD_STEP:   if (sts.div_last) state_d = ST_RESULT;
			ST_RESULT:     state_d = ST_OUT;
			ST_OUT:        if (out_ready) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		in_ready   = (state_q == ST_IDLE);
		out_valid  = (state_q == ST_OUT);
		unique case (state_q)
			ST_IDLE:       if (in_valid) begin
				cmd.load_req = 1'b1;
				cmd.clr_acc  = 1'b1;
			end
			ST_DISPATCH:   if (sts.kind == KIND_RESTART) cmd.restart = 1'b1;
			ST_HASH_INIT:  cmd.hash_init = 1'b1;
			ST_HASH_ROUND: cmd.hash_round = 1'b1;
			ST_HASH_FINAL: cmd.hash_final = 1'b1;
			ST_TAKE_BYTE:  cmd.take_byte = 1'b1;
			ST_LIMIT_INIT: cmd.lim_init = 1'b1;
			ST_LIMIT_STEP: cmd.div_step = 1'b1;
			// keep the word for the modulo unless it is drawn again
			ST_CHECK:      if (sts.reject) cmd.clr_acc = 1'b1;
			ST_MOD_INIT:   cmd.mod_init = 1'b1;
			ST_MOD_STEP:   cmd.div_step = 1'b1;
			ST_RESULT: begin
				if (sts.kind == KIND_RESTART || (sts.kind == KIND_UNIFORM && sts.small_bound))
					cmd.set_zero = 1'b1;
				else if (sts.kind == KIND_UNIFORM)
					cmd.set_rem = 1'b1;
				else
					cmd.set_acc = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### rtl/scrs_dpath.sv
// Datapath for the SHA-256 counter-mode byte stream: seed registers, block
// counter, SHA-256 round unit, digest buffer, byte gatherer, shared divider.
// Depends on scrs_pkg.
`default_nettype none
module scrs_dpath (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [1:0]        cfg_sel,
	input  wire               cfg_hit,
	input  wire  [63:0]       cfg_data,
	input  wire  [1:0]        kind,
	input  wire  [31:0]       bound,
	input  scrs_pkg::dp_cmd_t cmd,
	output scrs_pkg::dp_sts_t sts,
	output logic [31:0]       value
);
	import scrs_pkg::*;

	logic [63:0] seed_q [4];
	logic [63:0] counter_q;
	logic [5:0]  rdpos_q;
	logic [1:0]  kind_q;
	logic [31:0] bound_q;
	logic [31:0] w_q [16];
	logic [31:0] wv_q [8];
	logic [5:0]  round_q;
	logic [255:0] buf_q;
	logic [31:0] acc_q;
	logic [2:0]  nbytes_q;
	logic [31:0] limit_q;
	logic [32:0] dividend_q;
	logic [32:0] rem_q;
	logic [5:0]  dstep_q;
	logic        lim_mode_q;
	logic [31:0] value_q;

	// seed registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) seed_q[i] <= '0;
		end else if (cfg_we && cfg_hit) begin
			seed_q[cfg_sel] <= cfg_data;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q  <= kind;
			bound_q <= bound;
		end
	end

	// message schedule and compression round
	logic [31:0] s0, s1, w_new, t1, t2;
	always_comb begin
		s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		t1    = wv_q[7] + (rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25))
		        + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6])) + ROUND_K[round_q] + w_q[0];
		t2    = (rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22))
		        + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.hash_init) begin
			for (int i = 0; i < 8; i++) begin
				w_q[i] <= seed_q[i / 2][(1 - (i % 2)) * 32 +: 32];
				wv_q[i] <= INIT_H[i];
			end
			w_q[8]  <= counter_q[63:32];
			w_q[9]  <= counter_q[31:0];
			w_q[10] <= 32'h80000000;
			for (int i = 11; i < 15; i++) w_q[i] <= '0;
			w_q[15] <= 32'h00000140;
		end else if (cmd.hash_round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd.hash_init) begin
			round_q <= '0;
		end else if (cmd.hash_round) begin
			round_q <= round_q + 6'd1;
		end
	end

	// digest buffer, byte 0 in the top bits; shifts left as bytes are read
	always_ff @(posedge clk) begin
		if (cmd.hash_final) begin
			for (int i = 0; i < 8; i++) buf_q[(7 - i) * 32 +: 32] <= INIT_H[i] + wv_q[i];
		end else if (cmd.take_byte) begin
			buf_q <= {buf_q[247:0], 8'h00};
		end
	end

	// counter and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			rdpos_q   <= 6'(DIGEST_BYTES);
		end else if (cmd.restart) begin
			counter_q <= '0;
			rdpos_q   <= 6'(DIGEST_BYTES);
		end else if (cmd.hash_final) begin
			counter_q <= counter_q + 64'd1;
			rdpos_q   <= '0;
		end else if (cmd.take_byte) begin
			rdpos_q   <= rdpos_q + 6'd1;
		end
	end

	// byte gatherer
	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			acc_q    <= '0;
			nbytes_q <= '0;
		end else if (cmd.take_byte) begin
			acc_q    <= {acc_q[23:0], buf_q[255:248] & BYTE_MASK};
			nbytes_q <= nbytes_q + 3'd1;
		end
	end

	// shared restoring divider: 2^32/n (limit) or word mod n
	logic [33:0] trial;
	assign trial = {rem_q, dividend_q[32]} - {2'b00, bound_q};
	always_ff @(posedge clk) begin
		if (cmd.lim_init || cmd.mod_init) begin
			dividend_q <= cmd.lim_init ? 33'h1_0000_0000 : {1'b0, acc_q};
			rem_q      <= '0;
			dstep_q    <= '0;
			lim_mode_q <= cmd.lim_init;
		end else if (cmd.div_step) begin
			dividend_q <= {dividend_q[31:0], 1'b0};
			if (!trial[33]) begin
				rem_q  <= trial[32:0];
			end else begin
				rem_q  <= {rem_q[31:0], dividend_q[32]};
			end
			dstep_q <= dstep_q + 6'd1;
		end
	end

	// limit = floor(2^32/n)*n = 2^32 - (2^32 mod n); takes the final remainder
	logic [32:0] rem_next;
	assign rem_next = trial[33] ? {rem_q[31:0], dividend_q[32]} : trial[32:0];
	always_ff @(posedge clk) begin
		if (cmd.div_step && dstep_q == 6'd32 && lim_mode_q)
			limit_q <= 32'(33'h1_0000_0000 - rem_next);
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.set_zero)     value_q <= '0;
		else if (cmd.set_acc) value_q <= acc_q;
		else if (cmd.set_rem) value_q <= rem_q[31:0];
	end

	// limit_q of zero stands for 2^32 (n a power of two): nothing is rejected
	assign sts.kind        = kind_t'(kind_q);
	assign sts.small_bound = (bound_q[31:1] == '0);
	assign sts.buf_empty   = (rdpos_q == 6'(DIGEST_BYTES));
	assign sts.buf_last    = (rdpos_q == 6'(DIGEST_BYTES - 1));
	assign sts.round_last  = (round_q == 6'd63);
	assign sts.acc_full    = (nbytes_q == 3'd3);
	assign sts.div_last    = (dstep_q == 6'd32);
	assign sts.reject      = (limit_q != '0) && (acc_q >= limit_q);
	assign value           = value_q;

endmodule
`default_nettype wire

### rtl/sha256_counter_random_stream.sv
// Top level of the SHA-256 counter-mode byte stream. Instantiates scrs_ctrl
// and scrs_dpath; depends on scrs_pkg.
`default_nettype none
// One request at a time. Each buffer refill runs the 64-round SHA-256
// compression (one round per cycle in a single round unit). A uniform
// request with n above 1 first computes the rejection limit, checks each
// drawn word against it and ends with the final modulo (one bit per cycle in
// a shared restoring divider), and repeats its word draw on each rejection.
// The result stays in an output register until taken; the seed registers are
// written through cfg_we/cfg_addr/cfg_data and take effect at the next refill.
module sha256_counter_random_stream (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  kind,
	input  wire  [31:0] bound,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] value,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_addr,
	input  wire  [63:0] cfg_data
);
	import scrs_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	scrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	scrs_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_sel  (cfg_addr),
		.cfg_hit  (1'b1),
		.cfg_data (cfg_data),
		.kind     (kind),
		.bound    (bound),
		.cmd      (cmd),
		.sts      (sts),
		.value    (value)
	);

`ifndef NO_ASSERTIONS
	// a refill only starts when the buffer is empty
	a_refill_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hash_init |-> sts.buf_empty) else $error("refill with data left");
	// the buffer is never read while empty
	a_read_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_byte |-> !sts.buf_empty) else $error("read of empty buffer");
	// a result is presented in the cycle after it is set
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.set_zero || cmd.set_acc || cmd.set_rem) |=> out_valid)
		else $error("result not presented");
`endif

endmodule
`default_nettype wire
